// File: src/r1mu_pkg.sv
`default_nettype none
package r1mu_pkg;

  // store geometry
  localparam int MAX_ROWS  = 16;
  localparam int MAX_COLS  = 16;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int MAX_ELEMS = MAX_ROWS * MAX_COLS;
  localparam int ELEM_W    = 32;

  // configuration
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  // results
  localparam int SUM_W  = 63;
  localparam int ROOT_W = 32;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic KIND_DIST = 1'b0;
  localparam logic KIND_NORM = 1'b1;

  // request codes
  localparam logic [2:0] REQ_WR_M = 3'd0;
  localparam logic [2:0] REQ_WR_A = 3'd1;
  localparam logic [2:0] REQ_WR_B = 3'd2;
  localparam logic [2:0] REQ_DIST = 3'd3;
  localparam logic [2:0] REQ_SUB  = 3'd4;
  localparam logic [2:0] REQ_NORM = 3'd5;

  // command queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam logic [QPTR_W:0] QCNT_FULL = (QPTR_W + 1)'(QDEPTH);

  typedef struct packed {
    logic [2:0]              op;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [ELEM_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] x;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage
`default_nettype wire

// File: src/r1mu_front.sv
`default_nettype none
module r1mu_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [2:0]     in_tuser,
  input  wire logic [39:0]    in_tdata,
  output logic                q_valid,
  output r1mu_pkg::cmd_t      q_cmd,
  input  wire logic           q_pop
);
  import r1mu_pkg::*;

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              known, push, pop;
  cmd_t              cmd_in;

  // sort out codes that mean nothing; they are taken and dropped
  always_comb begin
    unique case (in_tuser) inside
      REQ_WR_M, REQ_WR_A, REQ_WR_B, REQ_DIST, REQ_SUB, REQ_NORM: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign cmd_in.op    = in_tuser;
  assign cmd_in.row   = in_tdata[3:0];
  assign cmd_in.col   = in_tdata[7:4];
  assign cmd_in.value = in_tdata[39:8];

  assign in_tready = (count_r != QCNT_FULL);
  assign push      = in_tvalid && in_tready && known;
  assign q_valid   = (count_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_cmd     = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
    end
  end

endmodule
`default_nettype wire

// File: src/r1mu_isqrt.sv
`default_nettype none
module r1mu_isqrt (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  r1mu_pkg::sqrt_req_t req,
  output r1mu_pkg::sqrt_rsp_t rsp
);
  import r1mu_pkg::*;

  logic [63:0] rem_r, res_r, bit_r, trial;
  logic [4:0]  step_r;
  logic        busy_r, done_r;

  assign trial    = res_r + bit_r;
  assign rsp.done = done_r;
  assign rsp.root = res_r[ROOT_W-1:0];

  // one result bit per cycle, 32 result bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {1'b0, req.x};
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: src/r1mu_back.sv
`default_nettype none
module r1mu_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [r1mu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [r1mu_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           q_valid,
  input  r1mu_pkg::cmd_t                      q_cmd,
  output logic                                q_pop,
  output r1mu_pkg::sqrt_req_t                 sq_req,
  input  r1mu_pkg::sqrt_rsp_t                 sq_rsp,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [63:0]                         out_tdata,
  output logic [1:0]                          out_tuser
);
  import r1mu_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_ROOT  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  // control
  logic [2:0]       state_r, state_nxt;
  logic [2:0]       op_r;
  logic [CFG_W-1:0] rows_r, cols_r, nr, nc;
  logic [ROW_W-1:0] i_r;
  logic [COL_W-1:0] j_r;
  logic             last_j, last_i, pipe_empty, start_op, load_out;
  logic             pend_r;

  // storage
  logic [ELEM_W-1:0]        mem [MAX_ELEMS];
  logic [MAX_ELEMS-1:0]     elem_vld_r;
  logic signed [ELEM_W-1:0] vec_a_r [MAX_ROWS];
  logic signed [ELEM_W-1:0] vec_b_r [MAX_COLS];
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr, raddr;
  logic [ELEM_W-1:0]        mem_wdata;

  // pipeline
  logic                     s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic [ADDR_W-1:0]        s1_addr_r, s2_addr_r;
  logic [ELEM_W-1:0]        mem_q_r;
  logic                     vld_q_r;
  logic signed [ELEM_W-1:0] a1_r, b1_r, m1, m2_r;
  logic signed [63:0]       p, p_r;
  logic [48:0]              diff;
  logic [ELEM_W-1:0]        clamp_val;
  logic                     sub_sat;
  logic [65:0]              d, dmag;
  logic [31:0]              mmag;
  logic [15:0]              h_r;
  logic [31:0]              l_r;
  logic                     big3_r, big4_r;
  logic [31:0]              hh_r;
  logic [47:0]              hl, hl_r;
  logic [63:0]              ll_r;
  logic [95:0]              full;
  logic [63:0]              dval;
  logic                     dsat;
  logic [SUM_W-1:0]         sq, sq_r;
  logic                     sqf, sqf_r;
  logic [SUM_W-1:0]         acc_r;
  logic                     accf_r;
  logic [63:0]              acc_sum;
  logic [ROOT_W-1:0]        root_r;

  // output register
  logic             out_v_r, out_kind_r, out_sat_r;
  logic [SUM_W-1:0] out_val_r;

  assign nr = (rows_r > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_r;
  assign nc = (cols_r > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cols_r;

  assign last_j     = ({1'b0, j_r} == CFG_W'(nc - 1'b1));
  assign last_i     = ({1'b0, i_r} == CFG_W'(nr - 1'b1));
  assign pipe_empty = !(s1_v_r || s2_v_r || s3_v_r || s4_v_r || s5_v_r);
  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign start_op   = q_pop && ((q_cmd.op == REQ_DIST) || (q_cmd.op == REQ_SUB) ||
                                (q_cmd.op == REQ_NORM));
  assign load_out   = (state_r == ST_EMIT) && (!out_v_r || out_tready);

  assign sq_req.start = (state_r == ST_DRAIN) && pipe_empty && (op_r == REQ_NORM);
  assign sq_req.x     = acc_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_op) begin
          state_nxt = ((nr == '0) || (nc == '0)) ? ST_DRAIN : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (last_i && last_j) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          if (op_r == REQ_NORM)      state_nxt = ST_ROOT;
          else if (op_r == REQ_DIST) state_nxt = ST_EMIT;
          else                       state_nxt = ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (sq_rsp.done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory write: element writes when idle, write-back of a subtract otherwise
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s2_addr_r;
    mem_wdata = clamp_val;
    if (q_pop && (q_cmd.op == REQ_WR_M)) begin
      mem_we    = 1'b1;
      mem_waddr = {q_cmd.row, q_cmd.col};
      mem_wdata = q_cmd.value;
    end else if (s2_v_r && (op_r == REQ_SUB)) begin
      mem_we = 1'b1;
    end
  end

  assign raddr = {i_r, j_r};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.op == REQ_WR_A)) vec_a_r[q_cmd.row] <= q_cmd.value;
    if (q_pop && (q_cmd.op == REQ_WR_B)) vec_b_r[q_cmd.col] <= q_cmd.value;
  end

  // stage 1: product of the vector elements
  assign m1 = vld_q_r ? signed'(mem_q_r) : '0;
  assign p  = a1_r * b1_r;

  // stage 2: subtract with clamp, distance magnitude
  always_comb begin
    diff      = {{17{m2_r[31]}}, m2_r} - {p_r[63], p_r[63:16]};
    clamp_val = diff[31:0];
    sub_sat   = 1'b0;
    if (!diff[48] && (diff[47:31] != '0)) begin
      clamp_val = 32'h7FFF_FFFF;
      sub_sat   = 1'b1;
    end else if (diff[48] && (diff[47:31] != '1)) begin
      clamp_val = 32'h8000_0000;
      sub_sat   = 1'b1;
    end
  end

  assign d    = {{2{p_r[63]}}, p_r} - {{18{m2_r[31]}}, m2_r, 16'b0};
  assign dmag = d[65] ? (~d + 1'b1) : d;
  assign mmag = m2_r[31] ? (~m2_r + 1'b1) : m2_r;

  // stage 3: partial products of the square
  assign hl = h_r * l_r;

  // stage 4: square reassembled and truncated
  always_comb begin
    full = {hh_r, 64'b0} + {15'b0, hl_r, 33'b0} + {32'b0, ll_r};
    dval = full[95:32];
    dsat = big4_r || dval[63];
    if (op_r == REQ_NORM) begin
      sq  = ll_r[SUM_W-1:0];
      sqf = 1'b0;
    end else begin
      sq  = dsat ? SUM_MAX : dval[SUM_W-1:0];
      sqf = dsat;
    end
  end

  // stage 5: saturating accumulate
  assign acc_sum = {1'b0, acc_r} + {1'b0, sq_r};

  always_ff @(posedge clk) begin
    vld_q_r   <= elem_vld_r[raddr];
    a1_r      <= vec_a_r[i_r];
    b1_r      <= vec_b_r[j_r];
    s1_addr_r <= raddr;
    p_r       <= p;
    m2_r      <= m1;
    s2_addr_r <= s1_addr_r;
    h_r       <= (op_r == REQ_NORM) ? 16'b0 : dmag[47:32];
    l_r       <= (op_r == REQ_NORM) ? mmag : dmag[31:0];
    big3_r    <= (op_r != REQ_NORM) && (dmag[65:48] != '0);
    hh_r      <= h_r * h_r;
    hl_r      <= hl;
    ll_r      <= l_r * l_r;
    big4_r    <= big3_r;
    sq_r      <= sq;
    sqf_r     <= sqf;
    if (sq_rsp.done) root_r <= sq_rsp.root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      op_r       <= REQ_DIST;
      rows_r     <= CFG_W'(16);
      cols_r     <= CFG_W'(16);
      i_r        <= '0;
      j_r        <= '0;
      elem_vld_r <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      s4_v_r     <= 1'b0;
      s5_v_r     <= 1'b0;
      acc_r      <= '0;
      accf_r     <= 1'b0;
      pend_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && (cfg_index == CFG_ROWS)) rows_r <= cfg_wdata;
      if (cfg_we && (cfg_index == CFG_COLS)) cols_r <= cfg_wdata;
      if (mem_we) elem_vld_r[mem_waddr] <= 1'b1;

      s1_v_r <= (state_r == ST_SWEEP);
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;

      if (start_op) begin
        op_r   <= q_cmd.op;
        i_r    <= '0;
        j_r    <= '0;
        acc_r  <= '0;
        accf_r <= 1'b0;
      end else begin
        if (state_r == ST_SWEEP) begin
          if (last_j) begin
            j_r <= '0;
            i_r <= i_r + 1'b1;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        if (s5_v_r) begin
          if (acc_sum[63]) begin
            acc_r  <= SUM_MAX;
            accf_r <= 1'b1;
          end else begin
            acc_r  <= acc_sum[SUM_W-1:0];
            accf_r <= accf_r || sqf_r;
          end
        end
      end

      if (s2_v_r && (op_r == REQ_SUB) && sub_sat) pend_r <= 1'b1;
      else if (load_out)                           pend_r <= 1'b0;

      if (load_out)        out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind_r <= (op_r == REQ_NORM) ? KIND_NORM : KIND_DIST;
      out_val_r  <= (op_r == REQ_NORM) ? {{(SUM_W - ROOT_W){1'b0}}, root_r} : acc_r;
      out_sat_r  <= accf_r || pend_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_val_r};
  assign out_tuser  = {out_sat_r, out_kind_r};

endmodule
`default_nettype wire

// File: src/rank_one_matrix_update_unit.sv
// order: a transfer enters the command queue, and a write is carried out from it while idle
// distance result offered after rows*cols sweep and drain; subtract holds for sweep and drain
// norm adds the square root, one result bit a cycle
// throughput: writes one per cycle between queries; queries one at a time, paced by the sweep
// reset: synchronous active-low rst_n clears the store (valid bits), queue, flags and results
`default_nettype none
module rank_one_matrix_update_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [r1mu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [r1mu_pkg::CFG_W-1:0]     cfg_wdata,
  // request channel
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [39:0]                    in_tdata,  // row[3:0], col[7:4], value[39:8]
  input  wire logic [2:0]                     in_tuser,  // req_type[2:0]
  // result channel
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [63:0]                         out_tdata, // result_value[62:0], zero pad [63]
  output logic [1:0]                          out_tuser  // result_kind[0], saturated[1]
);
  import r1mu_pkg::*;

  // front to back: queued commands
  logic      q_valid, q_pop;
  cmd_t      q_cmd;
  // back to root unit
  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;

  // front: takes transfers while the queue has room, drops unknown codes, queues the rest
  r1mu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  // back: store, vectors, element pipeline, accumulator and output register
  r1mu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .sq_req     (sq_req),
    .sq_rsp     (sq_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // iterative integer square root for the norm
  r1mu_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

endmodule
`default_nettype wire

// File: src/r1mu_checker.sv
`default_nettype none
module r1mu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // a norm fits in 32 bits
  a_norm_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[62:32] == '0)
    else $error("norm wider than 32 bits");

  // pad bit stays clear
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[63])
    else $error("pad bit set");

endmodule

bind rank_one_matrix_update_unit r1mu_checker u_checker (.*);
`default_nettype wire
